@@ hw/rtl/lkvc_pkg.sv @@
//------------------------------------------------------------------------------
// LRU key-value cache package
// Shared constants, command codes and the per-slot flag bundle.
//------------------------------------------------------------------------------
`default_nettype none

package lkvc_pkg;

   // Fixed widths of the request, response and CSR fields
   localparam int WORD_W = 64;
   localparam int CMD_W  = 2;
   localparam int CAP_W  = 5;

   // Defaults for the top-level parameters
   localparam int ENTRIES_DEF    = 16;
   localparam int KEY_BITS_DEF   = 64;
   localparam int VALUE_BITS_DEF = 64;

   localparam logic [CAP_W-1:0] CAP_RESET = 5'd16;

   // Command codes; the fourth code is unused and changes nothing
   localparam logic [CMD_W-1:0] CMD_GET    = 2'd0;
   localparam logic [CMD_W-1:0] CMD_PUT    = 2'd1;
   localparam logic [CMD_W-1:0] CMD_REMOVE = 2'd2;

   // Result of comparing one stored slot against the current request
   typedef struct packed {
      logic match;  // valid slot holding the requested key
      logic lru;    // valid slot with the lowest rank
      logic free;   // slot not in use
      logic dec;    // valid slot ranked above the threshold
   } slot_flags_type;

endpackage

`default_nettype wire

@@ hw/rtl/lkvc_if.sv @@
//------------------------------------------------------------------------------
// LRU key-value cache channel interfaces
// Request and response channels with valid/ready handshake.
//------------------------------------------------------------------------------
`default_nettype none

interface lkvc_req_if import lkvc_pkg::*; ();
   logic              valid;
   logic              ready;
   logic [CMD_W-1:0]  cmd;
   logic [WORD_W-1:0] key;
   logic [WORD_W-1:0] value;

   modport source (output valid, output cmd, output key, output value, input ready);
   modport sink   (input valid, input cmd, input key, input value, output ready);
endinterface

interface lkvc_rsp_if import lkvc_pkg::*; ();
   logic              valid;
   logic              ready;
   logic              hit;
   logic [WORD_W-1:0] read_value;
   logic              inserted;
   logic              evicted;
   logic [WORD_W-1:0] victim_key;

   modport source (output valid, output hit, output read_value, output inserted,
                   output evicted, output victim_key, input ready);
   modport sink   (input valid, input hit, input read_value, input inserted,
                   input evicted, input victim_key, output ready);
endinterface

`default_nettype wire

@@ hw/rtl/lkvc_ram.sv @@
//------------------------------------------------------------------------------
// LRU key-value cache generic RAM
// One write port, one read port with registered read data.
//------------------------------------------------------------------------------
`default_nettype none

module lkvc_ram #(
   parameter  int WIDTH = 8,
   parameter  int DEPTH = 16,
   localparam int AW    = $clog2(DEPTH)
) (
   input  wire logic             clock,
   input  wire logic             we,
   input  wire logic [AW-1:0]    waddr,
   input  wire logic [WIDTH-1:0] wdata,
   input  wire logic [AW-1:0]    raddr,
   output logic      [WIDTH-1:0] rdata
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rdata_ff;

   always_ff @(posedge clock) begin
      if (we) begin
         mem_ff[waddr] <= wdata;
      end
      rdata_ff <= mem_ff[raddr];
   end

   assign rdata = rdata_ff;

endmodule

`default_nettype wire

@@ hw/rtl/lkvc_cmp_unit.sv @@
//------------------------------------------------------------------------------
// LRU key-value cache slot compare unit
// Shared key and rank comparator applied to one slot per cycle.
//------------------------------------------------------------------------------
`default_nettype none

module lkvc_cmp_unit import lkvc_pkg::*; #(
   parameter int KEY_BITS = KEY_BITS_DEF,
   parameter int RANK_W   = 4
) (
   input  wire logic                slot_valid,
   input  wire logic [KEY_BITS-1:0] key_rd,
   input  wire logic [KEY_BITS-1:0] key_ref,
   input  wire logic [RANK_W-1:0]   rank_rd,
   input  wire logic [RANK_W-1:0]   thr,
   output slot_flags_type           flags,
   output logic      [RANK_W-1:0]   rank_dec
);

   always_comb begin
      flags.match = slot_valid && (key_rd == key_ref);
      flags.lru   = slot_valid && (rank_rd == '0);
      flags.free  = !slot_valid;
      flags.dec   = slot_valid && (rank_rd > thr);
   end

   // step one place toward least recent
   assign rank_dec = rank_rd - RANK_W'(1);

endmodule

`default_nettype wire

@@ hw/rtl/lkvc_ctrl.sv @@
//------------------------------------------------------------------------------
// LRU key-value cache sequencer
// Scans the slots, decides the operation, sweeps the ranks if needed and commits.
//------------------------------------------------------------------------------
`default_nettype none

module lkvc_ctrl import lkvc_pkg::*; #(
   parameter  int ENTRIES    = ENTRIES_DEF,
   parameter  int KEY_BITS   = KEY_BITS_DEF,
   parameter  int VALUE_BITS = VALUE_BITS_DEF,
   localparam int IDX_W      = $clog2(ENTRIES),
   localparam int CNT_W      = $clog2(ENTRIES + 1)
) (
   input  wire logic                  clock,
   input  wire logic                  reset,
   lkvc_req_if.sink                   req,
   lkvc_rsp_if.source                 rsp,
   input  wire logic                  csr_we,
   input  wire logic [CAP_W-1:0]      csr_wdata,
   // slot read side (key and rank stores share the sweep address)
   output logic      [IDX_W-1:0]      slot_raddr,
   output logic      [IDX_W-1:0]      val_raddr,
   input  wire logic [KEY_BITS-1:0]   key_rdata,
   input  wire logic [VALUE_BITS-1:0] val_rdata,
   input  wire logic [IDX_W-1:0]      rank_rdata,
   // write side
   output logic                       key_we,
   output logic                       val_we,
   output logic      [IDX_W-1:0]      kv_waddr,
   output logic      [KEY_BITS-1:0]   key_wdata,
   output logic      [VALUE_BITS-1:0] val_wdata,
   output logic                       rank_we,
   output logic      [IDX_W-1:0]      rank_waddr,
   output logic      [IDX_W-1:0]      rank_wdata,
   // shared compare unit
   output logic                       cmp_valid,
   output logic      [KEY_BITS-1:0]   cmp_key_ref,
   output logic      [IDX_W-1:0]      cmp_thr,
   input  wire slot_flags_type        cmp_flags,
   input  wire logic [IDX_W-1:0]      cmp_rank_dec
);

   localparam int CMP_W = (CNT_W > CAP_W) ? CNT_W : CAP_W;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_SCAN,
      ST_DECIDE,
      ST_PASS,
      ST_FINISH
   } state_type;

   state_type             state_ff, state_in;
   logic [CMD_W-1:0]      cmd_ff, cmd_in;
   logic [KEY_BITS-1:0]   key_ff, key_in;
   logic [VALUE_BITS-1:0] val_ff, val_in;
   logic [CNT_W-1:0]      ptr_ff, ptr_in;
   logic                  rd_vld_ff, rd_vld_in;
   logic [IDX_W-1:0]      rd_idx_ff, rd_idx_in;
   logic                  found_ff, found_in;
   logic [IDX_W-1:0]      hit_idx_ff, hit_idx_in;
   logic [IDX_W-1:0]      hit_rank_ff, hit_rank_in;
   logic [IDX_W-1:0]      lru_idx_ff, lru_idx_in;
   logic [KEY_BITS-1:0]   evk_ff, evk_in;
   logic                  free_found_ff, free_found_in;
   logic [IDX_W-1:0]      free_idx_ff, free_idx_in;
   logic [IDX_W-1:0]      thr_ff, thr_in;
   logic [IDX_W-1:0]      fin_idx_ff, fin_idx_in;
   logic [IDX_W-1:0]      fin_rank_ff, fin_rank_in;
   logic                  fin_rank_we_ff, fin_rank_we_in;
   logic                  fin_val_we_ff, fin_val_we_in;
   logic                  fin_ins_ff, fin_ins_in;
   logic                  res_hit_ff, res_hit_in;
   logic                  res_rd_ff, res_rd_in;
   logic                  res_ev_ff, res_ev_in;
   logic [ENTRIES-1:0]    valid_ff, valid_in;
   logic [CNT_W-1:0]      count_ff, count_in;
   logic [CAP_W-1:0]      cap_ff, cap_in;
   logic                  rsp_valid_ff, rsp_valid_in;
   logic                  rsp_hit_ff, rsp_hit_in;
   logic [WORD_W-1:0]     rsp_rv_ff, rsp_rv_in;
   logic                  rsp_ins_ff, rsp_ins_in;
   logic                  rsp_ev_ff, rsp_ev_in;
   logic [WORD_W-1:0]     rsp_evk_ff, rsp_evk_in;

   logic             accept;
   logic             issue;
   logic             go_finish;
   logic             cmd_ok;
   logic             hit;
   logic             full;
   logic [CMP_W-1:0] cap_eff;

   assign req.ready = (state_ff == ST_IDLE);
   assign accept    = req.valid && req.ready;
   assign issue     = ((state_ff == ST_SCAN) || (state_ff == ST_PASS)) &&
                      (ptr_ff != CNT_W'(ENTRIES));
   assign go_finish = (state_ff == ST_FINISH) && (!rsp_valid_ff || rsp.ready);

   assign cmd_ok = (cmd_ff == CMD_GET) || (cmd_ff == CMD_PUT) || (cmd_ff == CMD_REMOVE);
   assign hit    = found_ff && cmd_ok;

   // clamp capacity into 1..ENTRIES
   always_comb begin
      cap_eff = CMP_W'(cap_ff);
      priority if (cap_eff == '0) begin
         cap_eff = CMP_W'(1);
      end else if (cap_eff > CMP_W'(ENTRIES)) begin
         cap_eff = CMP_W'(ENTRIES);
      end else begin
         cap_eff = CMP_W'(cap_ff);
      end
   end
   assign full = CMP_W'(count_ff) >= cap_eff;

   // memory and compare unit hookup
   assign slot_raddr  = ptr_ff[IDX_W-1:0];
   assign val_raddr   = hit_idx_ff;
   assign cmp_valid   = valid_ff[rd_idx_ff];
   assign cmp_key_ref = key_ff;
   assign cmp_thr     = thr_ff;

   assign key_we     = go_finish && fin_ins_ff;
   assign val_we     = go_finish && fin_val_we_ff;
   assign kv_waddr   = fin_idx_ff;
   assign key_wdata  = key_ff;
   assign val_wdata  = val_ff;
   assign rank_we    = ((state_ff == ST_PASS) && rd_vld_ff && cmp_flags.dec) ||
                       (go_finish && fin_rank_we_ff);
   assign rank_waddr = (state_ff == ST_PASS) ? rd_idx_ff : fin_idx_ff;
   assign rank_wdata = (state_ff == ST_PASS) ? cmp_rank_dec : fin_rank_ff;

   always_comb begin
      state_in       = state_ff;
      cmd_in         = cmd_ff;
      key_in         = key_ff;
      val_in         = val_ff;
      ptr_in         = ptr_ff;
      rd_vld_in      = 1'b0;
      rd_idx_in      = ptr_ff[IDX_W-1:0];
      found_in       = found_ff;
      hit_idx_in     = hit_idx_ff;
      hit_rank_in    = hit_rank_ff;
      lru_idx_in     = lru_idx_ff;
      evk_in         = evk_ff;
      free_found_in  = free_found_ff;
      free_idx_in    = free_idx_ff;
      thr_in         = thr_ff;
      fin_idx_in     = fin_idx_ff;
      fin_rank_in    = fin_rank_ff;
      fin_rank_we_in = fin_rank_we_ff;
      fin_val_we_in  = fin_val_we_ff;
      fin_ins_in     = fin_ins_ff;
      res_hit_in     = res_hit_ff;
      res_rd_in      = res_rd_ff;
      res_ev_in      = res_ev_ff;
      valid_in       = valid_ff;
      count_in       = count_ff;
      cap_in         = cap_ff;
      rsp_valid_in   = rsp_valid_ff && !rsp.ready;
      rsp_hit_in     = rsp_hit_ff;
      rsp_rv_in      = rsp_rv_ff;
      rsp_ins_in     = rsp_ins_ff;
      rsp_ev_in      = rsp_ev_ff;
      rsp_evk_in     = rsp_evk_ff;

      // capacity only changes while the store is empty
      if (csr_we && (count_ff == '0)) begin
         cap_in = csr_wdata;
      end

      unique case (state_ff)
         ST_IDLE: begin
            if (accept) begin
               cmd_in        = req.cmd;
               key_in        = req.key[KEY_BITS-1:0];
               val_in        = req.value[VALUE_BITS-1:0];
               ptr_in        = '0;
               found_in      = 1'b0;
               free_found_in = 1'b0;
               state_in      = ST_SCAN;
            end
         end
         ST_SCAN: begin
            if (issue) begin
               rd_vld_in = 1'b1;
               ptr_in    = ptr_ff + CNT_W'(1);
            end
            if (rd_vld_ff) begin
               if (cmp_flags.match) begin
                  found_in    = 1'b1;
                  hit_idx_in  = rd_idx_ff;
                  hit_rank_in = rank_rdata;
               end
               if (cmp_flags.lru) begin
                  lru_idx_in = rd_idx_ff;
                  evk_in     = key_rdata;
               end
               if (cmp_flags.free && !free_found_ff) begin
                  free_found_in = 1'b1;
                  free_idx_in   = rd_idx_ff;
               end
            end
            if (!issue) begin
               state_in = ST_DECIDE;
            end
         end
         ST_DECIDE: begin
            ptr_in         = '0;
            state_in       = ST_PASS;
            res_hit_in     = hit;
            res_rd_in      = hit && (cmd_ff == CMD_GET);
            res_ev_in      = 1'b0;
            fin_rank_we_in = 1'b0;
            fin_val_we_in  = 1'b0;
            fin_ins_in     = 1'b0;
            priority if (hit && ((cmd_ff == CMD_GET) || (cmd_ff == CMD_PUT))) begin
               // touch: close ranks above, then make it most recent
               thr_in         = hit_rank_ff;
               fin_idx_in     = hit_idx_ff;
               fin_rank_in    = IDX_W'(count_ff - CNT_W'(1));
               fin_rank_we_in = 1'b1;
               fin_val_we_in  = (cmd_ff == CMD_PUT);
            end else if (hit && (cmd_ff == CMD_REMOVE)) begin
               valid_in[hit_idx_ff] = 1'b0;
               count_in             = count_ff - CNT_W'(1);
               thr_in               = hit_rank_ff;
            end else if (cmd_ff == CMD_PUT) begin
               fin_ins_in     = 1'b1;
               fin_val_we_in  = 1'b1;
               fin_rank_we_in = 1'b1;
               if (full) begin
                  // evict the least recent slot, then reuse the lowest free slot
                  valid_in[lru_idx_ff] = 1'b0;
                  count_in             = count_ff - CNT_W'(1);
                  thr_in               = '0;
                  res_ev_in            = 1'b1;
                  fin_idx_in           = (free_found_ff && (free_idx_ff < lru_idx_ff)) ?
                                         free_idx_ff : lru_idx_ff;
                  fin_rank_in          = IDX_W'(count_ff - CNT_W'(1));
               end else begin
                  fin_idx_in  = free_idx_ff;
                  fin_rank_in = IDX_W'(count_ff);
                  state_in    = ST_FINISH;
               end
            end else begin
               state_in = ST_FINISH;
            end
         end
         ST_PASS: begin
            if (issue) begin
               rd_vld_in = 1'b1;
               ptr_in    = ptr_ff + CNT_W'(1);
            end else begin
               state_in = ST_FINISH;
            end
         end
         ST_FINISH: begin
            if (go_finish) begin
               state_in     = ST_IDLE;
               rsp_valid_in = 1'b1;
               rsp_hit_in   = res_hit_ff;
               rsp_rv_in    = res_rd_ff ? WORD_W'(val_rdata) : '0;
               rsp_ins_in   = fin_ins_ff;
               rsp_ev_in    = res_ev_ff;
               rsp_evk_in   = res_ev_ff ? WORD_W'(evk_ff) : '0;
               if (fin_ins_ff) begin
                  valid_in[fin_idx_ff] = 1'b1;
                  count_in             = count_ff + CNT_W'(1);
               end
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      state_ff       <= state_in;
      cmd_ff         <= cmd_in;
      key_ff         <= key_in;
      val_ff         <= val_in;
      ptr_ff         <= ptr_in;
      rd_vld_ff      <= rd_vld_in;
      rd_idx_ff      <= rd_idx_in;
      found_ff       <= found_in;
      hit_idx_ff     <= hit_idx_in;
      hit_rank_ff    <= hit_rank_in;
      lru_idx_ff     <= lru_idx_in;
      evk_ff         <= evk_in;
      free_found_ff  <= free_found_in;
      free_idx_ff    <= free_idx_in;
      thr_ff         <= thr_in;
      fin_idx_ff     <= fin_idx_in;
      fin_rank_ff    <= fin_rank_in;
      fin_rank_we_ff <= fin_rank_we_in;
      fin_val_we_ff  <= fin_val_we_in;
      fin_ins_ff     <= fin_ins_in;
      res_hit_ff     <= res_hit_in;
      res_rd_ff      <= res_rd_in;
      res_ev_ff      <= res_ev_in;
      valid_ff       <= valid_in;
      count_ff       <= count_in;
      cap_ff         <= cap_in;
      rsp_valid_ff   <= rsp_valid_in;
      rsp_hit_ff     <= rsp_hit_in;
      rsp_rv_ff      <= rsp_rv_in;
      rsp_ins_ff     <= rsp_ins_in;
      rsp_ev_ff      <= rsp_ev_in;
      rsp_evk_ff     <= rsp_evk_in;
      if (reset) begin
         state_ff     <= ST_IDLE;
         rd_vld_ff    <= 1'b0;
         valid_ff     <= '0;
         count_ff     <= '0;
         cap_ff       <= CAP_RESET;
         rsp_valid_ff <= 1'b0;
      end
   end

   assign rsp.valid      = rsp_valid_ff;
   assign rsp.hit        = rsp_hit_ff;
   assign rsp.read_value = rsp_rv_ff;
   assign rsp.inserted   = rsp_ins_ff;
   assign rsp.evicted    = rsp_ev_ff;
   assign rsp.victim_key = rsp_evk_ff;

   // occupancy count tracks the valid bits exactly
   a_count_matches_valid: assert property (@(posedge clock) disable iff (reset)
      count_ff == CNT_W'($countones(valid_ff)))
      else $error("entry count differs from number of valid slots");

   // an insert always lands on a slot not in use
   a_insert_free_slot: assert property (@(posedge clock) disable iff (reset)
      (go_finish && fin_ins_ff) |-> !valid_ff[fin_idx_ff])
      else $error("insert targets an occupied slot");

   // an eviction comes only with an insert of a missing key
   a_evict_with_insert: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && rsp_ev_ff) |-> (rsp_ins_ff && !rsp_hit_ff))
      else $error("eviction without insert of a new key");

   // read data is zero unless the key was found
   a_read_zero_on_miss: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && !rsp_hit_ff) |-> (rsp_rv_ff == '0))
      else $error("read value nonzero on a miss");

endmodule

`default_nettype wire

@@ hw/rtl/lru_key_value_cache_unit.sv @@
//------------------------------------------------------------------------------
// LRU key-value cache unit
// Fully associative key-value store with least-recently-used replacement.
//------------------------------------------------------------------------------
// Usage:
//  - req_ch carries one request (cmd, key, value); it is taken at a clock edge
//    with valid and ready high. cmd selects get, put or remove; the fourth
//    code changes nothing and returns an all-zero response.
//  - rsp_ch returns exactly one response per request, in order: hit, read
//    value, inserted, evicted and the evicted key.
//  - csr_we/csr_wdata write the capacity register (entries allowed before
//    eviction); a write is dropped unless the store is empty.
//  - Sequence: a request is compared against every slot, one slot per cycle,
//    through a single shared compare unit. Hits (get, put or remove) and
//    evictions then sweep the recency ranks once more through the same unit.
//    The next request is taken only after the response has been registered.
//  - A stalled response holds in its output register; the next request is
//    still taken and worked on, and stalls only at its own commit step.
//  - Reset clears all valid bits, the entry count and the response valid and
//    sets capacity to 16; the stores need no clearing.
//------------------------------------------------------------------------------
`default_nettype none

module lru_key_value_cache_unit import lkvc_pkg::*; #(
   parameter int ENTRIES    = ENTRIES_DEF,
   parameter int KEY_BITS   = KEY_BITS_DEF,
   parameter int VALUE_BITS = VALUE_BITS_DEF
) (
   input  wire logic             clock,
   input  wire logic             reset,
   lkvc_req_if.sink              req_ch,
   lkvc_rsp_if.source            rsp_ch,
   input  wire logic             csr_we,
   input  wire logic [CAP_W-1:0] csr_wdata
);

   localparam int IDX_W = $clog2(ENTRIES);

   // sweep address shared by key and rank stores
   logic [IDX_W-1:0]      slot_raddr;
   logic [IDX_W-1:0]      val_raddr;
   logic [KEY_BITS-1:0]   key_rdata;
   logic [VALUE_BITS-1:0] val_rdata;
   logic [IDX_W-1:0]      rank_rdata;

   logic                  key_we;
   logic                  val_we;
   logic [IDX_W-1:0]      kv_waddr;
   logic [KEY_BITS-1:0]   key_wdata;
   logic [VALUE_BITS-1:0] val_wdata;
   logic                  rank_we;
   logic [IDX_W-1:0]      rank_waddr;
   logic [IDX_W-1:0]      rank_wdata;

   logic                  cmp_valid;
   logic [KEY_BITS-1:0]   cmp_key_ref;
   logic [IDX_W-1:0]      cmp_thr;
   slot_flags_type        cmp_flags;
   logic [IDX_W-1:0]      cmp_rank_dec;

   // Key store: read during the slot scan, written on insert
   lkvc_ram #(
      .WIDTH (KEY_BITS),
      .DEPTH (ENTRIES)
   ) u_key_ram (
      .clock (clock),
      .we    (key_we),
      .waddr (kv_waddr),
      .wdata (key_wdata),
      .raddr (slot_raddr),
      .rdata (key_rdata)
   );

   // Value store: read at the hit slot, written on put
   lkvc_ram #(
      .WIDTH (VALUE_BITS),
      .DEPTH (ENTRIES)
   ) u_val_ram (
      .clock (clock),
      .we    (val_we),
      .waddr (kv_waddr),
      .wdata (val_wdata),
      .raddr (val_raddr),
      .rdata (val_rdata)
   );

   // Recency ranks: 0 is least recent among the valid slots
   lkvc_ram #(
      .WIDTH (IDX_W),
      .DEPTH (ENTRIES)
   ) u_rank_ram (
      .clock (clock),
      .we    (rank_we),
      .waddr (rank_waddr),
      .wdata (rank_wdata),
      .raddr (slot_raddr),
      .rdata (rank_rdata)
   );

   // Shared compare unit: one slot per cycle in both scan and rank sweep
   lkvc_cmp_unit #(
      .KEY_BITS (KEY_BITS),
      .RANK_W   (IDX_W)
   ) u_cmp (
      .slot_valid (cmp_valid),
      .key_rd     (key_rdata),
      .key_ref    (cmp_key_ref),
      .rank_rd    (rank_rdata),
      .thr        (cmp_thr),
      .flags      (cmp_flags),
      .rank_dec   (cmp_rank_dec)
   );

   // Sequencer, valid bits, occupancy, capacity and response register
   lkvc_ctrl #(
      .ENTRIES    (ENTRIES),
      .KEY_BITS   (KEY_BITS),
      .VALUE_BITS (VALUE_BITS)
   ) u_ctrl (
      .clock        (clock),
      .reset        (reset),
      .req          (req_ch),
      .rsp          (rsp_ch),
      .csr_we       (csr_we),
      .csr_wdata    (csr_wdata),
      .slot_raddr   (slot_raddr),
      .val_raddr    (val_raddr),
      .key_rdata    (key_rdata),
      .val_rdata    (val_rdata),
      .rank_rdata   (rank_rdata),
      .key_we       (key_we),
      .val_we       (val_we),
      .kv_waddr     (kv_waddr),
      .key_wdata    (key_wdata),
      .val_wdata    (val_wdata),
      .rank_we      (rank_we),
      .rank_waddr   (rank_waddr),
      .rank_wdata   (rank_wdata),
      .cmp_valid    (cmp_valid),
      .cmp_key_ref  (cmp_key_ref),
      .cmp_thr      (cmp_thr),
      .cmp_flags    (cmp_flags),
      .cmp_rank_dec (cmp_rank_dec)
   );

endmodule

`default_nettype wire
